// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL. The clock is clk and the reset is arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== hw/rtl/rpcm_pkg.sv =====
package rpcm_pkg;

	localparam int CHAN_W    = 2;
	localparam int TS_W      = 16;
	localparam int MS_W      = 32;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 3;
	localparam int CNT_W     = 3;
	localparam int UNIT_W    = 32;

	localparam logic [CNT_W-1:0] CNT_MAX = 3'd7;

	localparam int DEF_NUM_CHANNELS  = 4;
	localparam int DEF_TIMEIN_PULSES = 4;
	localparam int DEF_TIMER_BITS    = 16;

	localparam logic [CFG_W-1:0] RST_CHAN_MIN   = 16'd1000;
	localparam logic [CFG_W-1:0] RST_CHAN_MAX   = 16'd2000;
	localparam logic [CFG_W-1:0] RST_PULSE_MIN  = 16'd900;
	localparam logic [CFG_W-1:0] RST_PULSE_MAX  = 16'd2100;
	localparam logic [CFG_W-1:0] RST_PERIOD_MIN = 16'd2500;
	localparam logic [CFG_W-1:0] RST_PERIOD_MAX = 16'd25000;
	localparam logic [CFG_W-1:0] RST_QUIET      = 16'd25;
	localparam logic [CFG_W-1:0] RST_LOSS       = 16'd100;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CHAN_MIN   = 3'd0,
		REG_CHAN_MAX   = 3'd1,
		REG_PULSE_MIN  = 3'd2,
		REG_PULSE_MAX  = 3'd3,
		REG_PERIOD_MIN = 3'd4,
		REG_PERIOD_MAX = 3'd5,
		REG_QUIET      = 3'd6,
		REG_LOSS       = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [CFG_W-1:0] chan_min_us;
		logic [CFG_W-1:0] chan_max_us;
		logic [CFG_W-1:0] pulse_abs_min_us;
		logic [CFG_W-1:0] pulse_abs_max_us;
		logic [CFG_W-1:0] period_min_us;
		logic [CFG_W-1:0] period_max_us;
		logic [CFG_W-1:0] quiet_reset_ms;
		logic [CFG_W-1:0] loss_timeout_ms;
	} cfg_t;

	typedef struct packed {
		logic [UNIT_W-1:0] diff;
		logic              borrow;
	} alu_res_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_EDGE,
		S_E_PULSE,
		S_E_PERIOD,
		S_E_CHK_PMIN,
		S_E_CHK_PMAX,
		S_E_CHK_QMIN,
		S_E_CHK_QMAX,
		S_T_GAP,
		S_T_LOST,
		S_T_LO,
		S_T_HI,
		S_OUT
	} state_t;

endpackage

// ===== hw/rtl/rpcm_alu.sv =====
module rpcm_alu (
	input  logic [rpcm_pkg::UNIT_W-1:0] a,
	input  logic [rpcm_pkg::UNIT_W-1:0] b,
	output rpcm_pkg::alu_res_t          res
);
	import rpcm_pkg::*;

	logic [UNIT_W:0] full;

	// The borrow out of the subtraction is the unsigned a < b compare.
	assign full       = {1'b0, a} - {1'b0, b};
	assign res.diff   = full[UNIT_W-1:0];
	assign res.borrow = full[UNIT_W];

endmodule

// ===== hw/rtl/rpcm_core.sv =====
`include "assert_macros.svh"

module rpcm_core #(
	parameter int NUM_CHANNELS  = rpcm_pkg::DEF_NUM_CHANNELS,
	parameter int TIMEIN_PULSES = rpcm_pkg::DEF_TIMEIN_PULSES,
	parameter int TIMER_BITS    = rpcm_pkg::DEF_TIMER_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  rpcm_pkg::cfg_t               cfg,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         cmd,
	input  logic [rpcm_pkg::CHAN_W-1:0]  chan_sel,
	input  logic                         pin_level,
	input  logic [rpcm_pkg::TS_W-1:0]    edge_time_us,
	input  logic [rpcm_pkg::MS_W-1:0]    now_ms,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [rpcm_pkg::CHAN_W-1:0]  chan_out,
	output logic [rpcm_pkg::CFG_W-1:0]   chan_value_us,
	output logic                         chan_lost,
	output logic                         pulse_captured,
	output logic                         last_result
);
	import rpcm_pkg::*;

	localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam logic [CH_W-1:0]   LAST_CH = CH_W'(NUM_CHANNELS - 1);
	localparam logic [CHAN_W:0]   NCH     = (CHAN_W + 1)'(NUM_CHANNELS);
	localparam logic [CNT_W-1:0]  TIMEIN  = CNT_W'(TIMEIN_PULSES);

	state_t state_q, state_d;

	logic [CH_W-1:0]       c_q;
	logic                  cmd_q;
	logic                  lvl_q;
	logic [TS_W-1:0]       t_q;
	logic [MS_W-1:0]       now_q;
	logic [TIMER_BITS-1:0] pulse_q;
	logic [TIMER_BITS-1:0] period_q;
	logic                  ok_q;
	logic                  lo_q;
	logic [MS_W-1:0]       gap_q;
	logic                  cap_q;

	logic              prev_q  [NUM_CHANNELS];
	logic [TS_W-1:0]   rise_q  [NUM_CHANNELS];
	logic [TS_W-1:0]   fall_q  [NUM_CHANNELS];
	logic              pend_q  [NUM_CHANNELS];
	logic [CFG_W-1:0]  ppulse_q[NUM_CHANNELS];
	logic [CFG_W-1:0]  value_q [NUM_CHANNELS];
	logic              lost_q  [NUM_CHANNELS];
	logic [CNT_W-1:0]  cnt_q   [NUM_CHANNELS];
	logic [MS_W-1:0]   last_q  [NUM_CHANNELS];

	logic              out_valid_q;
	logic [CHAN_W-1:0] chan_out_q;
	logic [CFG_W-1:0]  value_out_q;
	logic              lost_out_q;
	logic              cap_out_q;
	logic              last_out_q;

	logic [UNIT_W-1:0] op_a, op_b;
	alu_res_t          alu;
	logic              accept;
	logic              out_load;
	logic              is_last;
	logic              in_range;
	logic [CNT_W-1:0]  cnt_inc;
	logic              timein_hit;
	logic              still_lost;

	rpcm_alu u_alu (
		.a   (op_a),
		.b   (op_b),
		.res (alu)
	);

	assign in_range   = {1'b0, chan_sel} < NCH;
	assign is_last    = !cmd_q || (c_q == LAST_CH);
	assign cnt_inc    = (cnt_q[c_q] == CNT_MAX) ? cnt_q[c_q] : cnt_q[c_q] + 3'd1;
	assign timein_hit = cnt_inc >= TIMEIN;
	assign still_lost = lost_q[c_q] && !(pend_q[c_q] && timein_hit);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (cmd) begin
						state_d = S_T_GAP;
					end else if (in_range) begin
						state_d = S_EDGE;
					end
				end
			end
			S_EDGE: begin
				if (lvl_q == prev_q[c_q] || lvl_q) begin
					state_d = S_OUT;
				end else begin
					state_d = S_E_PULSE;
				end
			end
			S_E_PULSE:    state_d = S_E_PERIOD;
			S_E_PERIOD:   state_d = S_E_CHK_PMIN;
			S_E_CHK_PMIN: state_d = S_E_CHK_PMAX;
			S_E_CHK_PMAX: state_d = S_E_CHK_QMIN;
			S_E_CHK_QMIN: state_d = S_E_CHK_QMAX;
			S_E_CHK_QMAX: state_d = S_OUT;
			S_T_GAP:      state_d = S_T_LOST;
			S_T_LOST:     state_d = still_lost ? S_OUT : S_T_LO;
			S_T_LO:       state_d = pend_q[c_q] ? S_T_HI : S_OUT;
			S_T_HI:       state_d = S_OUT;
			S_OUT: begin
				if (out_load) begin
					state_d = is_last ? S_IDLE : S_T_GAP;
				end
			end
			default:      state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_stall = (state_q != S_IDLE);
		accept   = in_valid && (state_q == S_IDLE);
		out_load = (state_q == S_OUT) && (!out_valid_q || !out_stall);
		op_a     = '0;
		op_b     = '0;
		unique case (state_q)
			S_E_PULSE: begin
				op_a = UNIT_W'(t_q);
				op_b = UNIT_W'(rise_q[c_q]);
			end
			S_E_PERIOD: begin
				op_a = UNIT_W'(t_q);
				op_b = UNIT_W'(fall_q[c_q]);
			end
			S_E_CHK_PMIN: begin
				op_a = UNIT_W'(pulse_q);
				op_b = UNIT_W'(cfg.pulse_abs_min_us);
			end
			S_E_CHK_PMAX: begin
				op_a = UNIT_W'(cfg.pulse_abs_max_us);
				op_b = UNIT_W'(pulse_q);
			end
			S_E_CHK_QMIN: begin
				op_a = UNIT_W'(period_q);
				op_b = UNIT_W'(cfg.period_min_us);
			end
			S_E_CHK_QMAX: begin
				op_a = UNIT_W'(cfg.period_max_us);
				op_b = UNIT_W'(period_q);
			end
			S_T_GAP: begin
				op_a = UNIT_W'(now_q);
				op_b = UNIT_W'(last_q[c_q]);
			end
			S_T_LOST: begin
				op_a = UNIT_W'(gap_q);
				op_b = UNIT_W'(cfg.quiet_reset_ms);
			end
			S_T_LO: begin
				if (pend_q[c_q]) begin
					op_a = UNIT_W'(ppulse_q[c_q]);
					op_b = UNIT_W'(cfg.chan_min_us);
				end else begin
					op_a = UNIT_W'(gap_q);
					op_b = UNIT_W'(cfg.loss_timeout_ms);
				end
			end
			S_T_HI: begin
				op_a = UNIT_W'(cfg.chan_max_us);
				op_b = UNIT_W'(ppulse_q[c_q]);
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd_q <= cmd;
					lvl_q <= pin_level;
					t_q   <= edge_time_us;
					now_q <= now_ms;
					cap_q <= 1'b0;
					c_q   <= cmd ? '0 : chan_sel[CH_W-1:0];
				end
			end
			S_E_PULSE:    pulse_q  <= alu.diff[TIMER_BITS-1:0];
			S_E_PERIOD:   period_q <= alu.diff[TIMER_BITS-1:0];
			S_E_CHK_PMIN: ok_q     <= !alu.borrow;
			S_E_CHK_PMAX: ok_q     <= ok_q && !alu.borrow;
			S_E_CHK_QMIN: ok_q     <= ok_q && !alu.borrow;
			S_E_CHK_QMAX: cap_q    <= ok_q && !alu.borrow;
			S_T_GAP:      gap_q    <= alu.diff[MS_W-1:0];
			S_T_LO:       lo_q     <= alu.borrow;
			S_OUT: begin
				if (out_load && !is_last) begin
					c_q <= c_q + 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				prev_q[i]   <= 1'b0;
				rise_q[i]   <= '0;
				fall_q[i]   <= '0;
				pend_q[i]   <= 1'b0;
				ppulse_q[i] <= '0;
				value_q[i]  <= '0;
				lost_q[i]   <= 1'b1;
				cnt_q[i]    <= '0;
				last_q[i]   <= '0;
			end
		end else begin
			unique case (state_q)
				S_EDGE: begin
					if (lvl_q && !prev_q[c_q]) begin
						rise_q[c_q] <= t_q;
						prev_q[c_q] <= 1'b1;
					end
				end
				S_E_CHK_QMAX: begin
					if (ok_q && !alu.borrow) begin
						pend_q[c_q]   <= 1'b1;
						ppulse_q[c_q] <= pulse_q[CFG_W-1:0];
					end
					fall_q[c_q] <= t_q;
					prev_q[c_q] <= 1'b0;
				end
				S_T_LOST: begin
					if (lost_q[c_q]) begin
						if (pend_q[c_q]) begin
							cnt_q[c_q] <= cnt_inc;
							if (timein_hit) begin
								lost_q[c_q] <= 1'b0;
							end else begin
								pend_q[c_q]   <= 1'b0;
								ppulse_q[c_q] <= '0;
								last_q[c_q]   <= now_q;
							end
						end else if (cnt_q[c_q] != '0 && !alu.borrow) begin
							cnt_q[c_q]  <= '0;
							last_q[c_q] <= now_q;
						end
					end
				end
				S_T_LO: begin
					if (!pend_q[c_q] && !alu.borrow) begin
						lost_q[c_q]  <= 1'b1;
						value_q[c_q] <= '0;
						last_q[c_q]  <= now_q;
						cnt_q[c_q]   <= '0;
					end
				end
				S_T_HI: begin
					if (lo_q) begin
						value_q[c_q] <= cfg.chan_min_us;
					end else if (alu.borrow) begin
						value_q[c_q] <= cfg.chan_max_us;
					end else begin
						value_q[c_q] <= ppulse_q[c_q];
					end
					pend_q[c_q]   <= 1'b0;
					ppulse_q[c_q] <= '0;
					last_q[c_q]   <= now_q;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			chan_out_q  <= CHAN_W'(c_q);
			value_out_q <= value_q[c_q];
			lost_out_q  <= lost_q[c_q];
			cap_out_q   <= cap_q;
			last_out_q  <= is_last;
		end
	end

	assign out_valid      = out_valid_q;
	assign chan_out       = chan_out_q;
	assign chan_value_us  = value_out_q;
	assign chan_lost      = lost_out_q;
	assign pulse_captured = cap_out_q;
	assign last_result    = last_out_q;

	`ASSERT_IMP(a_lost_reads_zero, out_valid_q && lost_out_q, value_out_q == '0)
	`ASSERT_IMP(a_capture_only_on_edge, out_valid_q && cap_out_q, last_out_q)
	`ASSERT_NXT(a_last_returns_idle, out_load && is_last, state_q == S_IDLE)

endmodule

// ===== hw/rtl/rc_pwm_pulse_capture_monitor.sv =====
// RC PWM pulse capture monitor with time-in and loss failsafe.
// The input channel (in_valid/in_stall) carries either a pin edge event (cmd 0)
// or a periodic update tick (cmd 1). The block takes one transaction at a time
// and holds in_stall high until every result of that transaction is in the
// output register. An edge event on a channel beyond the configured count
// gives no result; any other edge event gives one result, and a tick gives one
// result per channel, channel 0 first, with last_result on the final one.
// The subtractions and limit compares all run through one shared
// subtract-and-compare unit stepped by a sequencer. A rising or repeated edge
// goes from the edge check straight to the output register; a falling edge
// first forms the pulse width and the period and checks each against its two
// limits. A tick steps each channel through the gap and time-in checks and,
// as its state needs, the loss or low-clamp check and the high-clamp check.
// The output register holds a result while out_stall is high, and the
// sequencer waits at that point until the result is taken.
// Reset clears per-channel capture state, marks each channel lost with value 0
// and loads the default limits. Configuration writes (cfg_we) apply at once;
// the user must make them only while the block is idle; no logic enforces it.
module rc_pwm_pulse_capture_monitor #(
	parameter int NUM_CHANNELS  = rpcm_pkg::DEF_NUM_CHANNELS,
	parameter int TIMEIN_PULSES = rpcm_pkg::DEF_TIMEIN_PULSES,
	parameter int TIMER_BITS    = rpcm_pkg::DEF_TIMER_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [rpcm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rpcm_pkg::CFG_W-1:0]     cfg_wdata,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           cmd,
	input  logic [rpcm_pkg::CHAN_W-1:0]    chan_sel,
	input  logic                           pin_level,
	input  logic [rpcm_pkg::TS_W-1:0]      edge_time_us,
	input  logic [rpcm_pkg::MS_W-1:0]      now_ms,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [rpcm_pkg::CHAN_W-1:0]    chan_out,
	output logic [rpcm_pkg::CFG_W-1:0]     chan_value_us,
	output logic                           chan_lost,
	output logic                           pulse_captured,
	output logic                           last_result
);
	import rpcm_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.chan_min_us      <= RST_CHAN_MIN;
			cfg_q.chan_max_us      <= RST_CHAN_MAX;
			cfg_q.pulse_abs_min_us <= RST_PULSE_MIN;
			cfg_q.pulse_abs_max_us <= RST_PULSE_MAX;
			cfg_q.period_min_us    <= RST_PERIOD_MIN;
			cfg_q.period_max_us    <= RST_PERIOD_MAX;
			cfg_q.quiet_reset_ms   <= RST_QUIET;
			cfg_q.loss_timeout_ms  <= RST_LOSS;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_CHAN_MIN:   cfg_q.chan_min_us      <= cfg_wdata;
				REG_CHAN_MAX:   cfg_q.chan_max_us      <= cfg_wdata;
				REG_PULSE_MIN:  cfg_q.pulse_abs_min_us <= cfg_wdata;
				REG_PULSE_MAX:  cfg_q.pulse_abs_max_us <= cfg_wdata;
				REG_PERIOD_MIN: cfg_q.period_min_us    <= cfg_wdata;
				REG_PERIOD_MAX: cfg_q.period_max_us    <= cfg_wdata;
				REG_QUIET:      cfg_q.quiet_reset_ms   <= cfg_wdata;
				REG_LOSS:       cfg_q.loss_timeout_ms  <= cfg_wdata;
				default:        cfg_q.loss_timeout_ms  <= cfg_wdata;
			endcase
		end
	end

	rpcm_core #(
		.NUM_CHANNELS  (NUM_CHANNELS),
		.TIMEIN_PULSES (TIMEIN_PULSES),
		.TIMER_BITS    (TIMER_BITS)
	) u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.cmd            (cmd),
		.chan_sel       (chan_sel),
		.pin_level      (pin_level),
		.edge_time_us   (edge_time_us),
		.now_ms         (now_ms),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.chan_out       (chan_out),
		.chan_value_us  (chan_value_us),
		.chan_lost      (chan_lost),
		.pulse_captured (pulse_captured),
		.last_result    (last_result)
	);

endmodule

// ===== test/rpcm_channel_checker.sv =====
module rpcm_channel_checker
	import rpcm_pkg::*;
#(
	parameter int NUM_CHANNELS  = DEF_NUM_CHANNELS,
	parameter int TIMEIN_PULSES = DEF_TIMEIN_PULSES
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  logic                 cmd,
	input  logic [CHAN_W-1:0]    chan_sel,
	input  logic                 pin_level,
	input  logic [TS_W-1:0]      edge_time_us,
	input  logic [MS_W-1:0]      now_ms,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  logic [CHAN_W-1:0]    chan_out,
	input  logic [CFG_W-1:0]     chan_value_us,
	input  logic                 chan_lost,
	input  logic                 pulse_captured,
	input  logic                 last_result,
	output int                   mismatch_count,
	output int                   reports_due
);

	localparam logic CMD_TICK = 1'b1;

	typedef struct packed {
		logic [CHAN_W-1:0] chan;
		logic [CFG_W-1:0]  value;
		logic              lost;
		logic              captured;
		logic              last;
	} chan_report_t;

	chan_report_t expected_reports[$];
	chan_report_t oldest;
	int mismatches = 0;

	logic [CFG_W-1:0] lim_chan_min, lim_chan_max, lim_width_min, lim_width_max;
	logic [CFG_W-1:0] lim_period_min, lim_period_max, lim_quiet_ms, lim_loss_ms;

	logic             level_seen [NUM_CHANNELS];
	logic [TS_W-1:0]  rise_at    [NUM_CHANNELS];
	logic [TS_W-1:0]  fall_at    [NUM_CHANNELS];
	logic [TS_W-1:0]  held_width [NUM_CHANNELS];
	logic             held_ok    [NUM_CHANNELS];
	logic [CFG_W-1:0] value_now  [NUM_CHANNELS];
	logic             lost_now   [NUM_CHANNELS];
	logic [CNT_W-1:0] timein     [NUM_CHANNELS];
	logic [MS_W-1:0]  event_ms   [NUM_CHANNELS];

	task automatic push_report(input int ch, input logic captured, input logic last);
		chan_report_t r;
		r.chan     = CHAN_W'(ch);
		r.value    = value_now[ch];
		r.lost     = lost_now[ch];
		r.captured = captured;
		r.last     = last;
		expected_reports.push_back(r);
	endtask

	task automatic predict_edge(input logic [CHAN_W-1:0] ch, input logic lvl,
			input logic [TS_W-1:0] t);
		logic [TS_W-1:0] width;
		logic [TS_W-1:0] period;
		logic            captured;
		captured = 1'b0;
		if (int'(ch) >= NUM_CHANNELS)
			return;
		if (lvl != level_seen[ch]) begin
			if (lvl) begin
				rise_at[ch] = t;
			end else begin
				width  = t - rise_at[ch];
				period = t - fall_at[ch];
				if (width >= lim_width_min && width <= lim_width_max &&
						period >= lim_period_min && period <= lim_period_max) begin
					held_width[ch] = width;
					held_ok[ch]    = 1'b1;
					captured       = 1'b1;
				end
				fall_at[ch] = t;
			end
			level_seen[ch] = lvl;
		end
		push_report(int'(ch), captured, 1'b1);
	endtask

	task automatic predict_tick(input logic [MS_W-1:0] now);
		logic [MS_W-1:0] gap;
		for (int c = 0; c < NUM_CHANNELS; c++) begin
			// A lost channel needs TIMEIN_PULSES pulses before it is live again.
			if (lost_now[c]) begin
				gap = now - event_ms[c];
				if (held_ok[c]) begin
					if (timein[c] < CNT_MAX)
						timein[c]++;
					if (int'(timein[c]) >= TIMEIN_PULSES) begin
						lost_now[c] = 1'b0;
					end else begin
						held_ok[c]    = 1'b0;
						held_width[c] = '0;
						event_ms[c]   = now;
					end
				end else if (timein[c] != '0 && gap >= MS_W'(lim_quiet_ms)) begin
					timein[c]   = '0;
					event_ms[c] = now;
				end
			end
			if (!lost_now[c]) begin
				gap = now - event_ms[c];
				if (held_ok[c]) begin
					if (held_width[c] < lim_chan_min)
						value_now[c] = lim_chan_min;
					else if (held_width[c] > lim_chan_max)
						value_now[c] = lim_chan_max;
					else
						value_now[c] = held_width[c];
					held_ok[c]    = 1'b0;
					held_width[c] = '0;
					event_ms[c]   = now;
				end else if (gap >= MS_W'(lim_loss_ms)) begin
					lost_now[c]  = 1'b1;
					value_now[c] = '0;
					event_ms[c]  = now;
					timein[c]    = '0;
				end
			end
			push_report(c, 1'b0, c == NUM_CHANNELS - 1);
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_chan_min   = RST_CHAN_MIN;
			lim_chan_max   = RST_CHAN_MAX;
			lim_width_min  = RST_PULSE_MIN;
			lim_width_max  = RST_PULSE_MAX;
			lim_period_min = RST_PERIOD_MIN;
			lim_period_max = RST_PERIOD_MAX;
			lim_quiet_ms   = RST_QUIET;
			lim_loss_ms    = RST_LOSS;
			for (int c = 0; c < NUM_CHANNELS; c++) begin
				level_seen[c] = 1'b0;
				rise_at[c]    = '0;
				fall_at[c]    = '0;
				held_width[c] = '0;
				held_ok[c]    = 1'b0;
				value_now[c]  = '0;
				lost_now[c]   = 1'b1;
				timein[c]     = '0;
				event_ms[c]   = '0;
			end
			expected_reports.delete();
			reports_due    <= 0;
			mismatch_count <= mismatches;
		end else begin
			// Results leave before the transaction taken at this edge can produce any.
			if (out_valid && !out_stall) begin
				if (expected_reports.size() == 0) begin
					$error("result for channel %0d with no transaction waiting", chan_out);
					mismatches++;
				end else begin
					oldest = expected_reports.pop_front();
					check_field("chan_out", 32'(oldest.chan), 32'(chan_out));
					check_field("chan_value_us", 32'(oldest.value), 32'(chan_value_us));
					check_field("chan_lost", 32'(oldest.lost), 32'(chan_lost));
					check_field("pulse_captured", 32'(oldest.captured), 32'(pulse_captured));
					check_field("last_result", 32'(oldest.last), 32'(last_result));
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_CHAN_MIN:   lim_chan_min   = cfg_wdata;
					REG_CHAN_MAX:   lim_chan_max   = cfg_wdata;
					REG_PULSE_MIN:  lim_width_min  = cfg_wdata;
					REG_PULSE_MAX:  lim_width_max  = cfg_wdata;
					REG_PERIOD_MIN: lim_period_min = cfg_wdata;
					REG_PERIOD_MAX: lim_period_max = cfg_wdata;
					REG_QUIET:      lim_quiet_ms   = cfg_wdata;
					REG_LOSS:       lim_loss_ms    = cfg_wdata;
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				if (cmd == CMD_TICK)
					predict_tick(now_ms);
				else
					predict_edge(chan_sel, pin_level, edge_time_us);
			end
			reports_due    <= expected_reports.size();
			mismatch_count <= mismatches;
		end
	end

endmodule

// ===== test/tb_rc_pwm_pulse_capture_monitor.sv =====
module tb_rc_pwm_pulse_capture_monitor;
	import rpcm_pkg::*;

	localparam logic CMD_EDGE  = 1'b0;
	localparam logic CMD_TICK  = 1'b1;
	localparam int   LONG_HOLD = 60;

	logic                 clk            = 1'b0;
	logic                 arst_n         = 1'b0;
	logic                 cfg_we         = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index      = '0;
	logic [CFG_W-1:0]     cfg_wdata      = '0;
	logic                 in_valid       = 1'b0;
	logic                 in_stall;
	logic                 cmd            = 1'b0;
	logic [CHAN_W-1:0]    chan_sel       = '0;
	logic                 pin_level      = 1'b0;
	logic [TS_W-1:0]      edge_time_us   = '0;
	logic [MS_W-1:0]      now_ms         = '0;
	logic                 out_valid;
	logic                 out_stall      = 1'b0;
	logic [CHAN_W-1:0]    chan_out;
	logic [CFG_W-1:0]     chan_value_us;
	logic                 chan_lost;
	logic                 pulse_captured;
	logic                 last_result;
	int                   mismatch_count;
	int                   reports_due;

	logic                 calm           = 1'b0;
	logic                 hold_req       = 1'b0;
	int                   stall_left     = 0;
	int                   items_sent     = 0;
	logic [TS_W-1:0]      clock_us [4];
	logic [MS_W-1:0]      ms_clock;

	rc_pwm_pulse_capture_monitor dut (.*);

	rpcm_channel_checker #(
		.NUM_CHANNELS (DEF_NUM_CHANNELS),
		.TIMEIN_PULSES(DEF_TIMEIN_PULSES)
	) u_checker (.*);

	always #5 clk = ~clk;

	initial begin
		#1000000;
		$display("tb_rc_pwm_pulse_capture_monitor: FAIL");
		$finish;
	end

	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
		end else if (hold_req) begin
			hold_req   <= 1'b0;
			out_stall  <= 1'b1;
			stall_left = LONG_HOLD;
		end else if (!calm && $urandom_range(0, 3) == 0) begin
			out_stall  <= 1'b1;
			stall_left = $urandom_range(0, 3);
		end else begin
			out_stall <= 1'b0;
		end
	end

	task automatic send_item(input logic c, input logic [CHAN_W-1:0] ch, input logic lvl,
			input logic [TS_W-1:0] t, input logic [MS_W-1:0] now);
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid     <= 1'b1;
		cmd          <= c;
		chan_sel     <= ch;
		pin_level    <= lvl;
		edge_time_us <= t;
		now_ms       <= now;
		do @(posedge clk); while (in_stall);
		items_sent++;
	endtask

	task automatic send_edge(input logic [CHAN_W-1:0] ch, input logic lvl,
			input logic [TS_W-1:0] t);
		send_item(CMD_EDGE, ch, lvl, t, $urandom);
	endtask

	task automatic send_tick(input logic [MS_W-1:0] now);
		send_item(CMD_TICK, CHAN_W'($urandom), 1'($urandom), TS_W'($urandom), now);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (reports_due != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t r, input logic [CFG_W-1:0] v);
		cfg_we    <= 1'b1;
		cfg_index <= r;
		cfg_wdata <= v;
		@(posedge clk);
	endtask

	task automatic set_limits(input logic [CFG_W-1:0] cmin, cmax, wmin, wmax, pmin, pmax,
			quiet, loss);
		drain();
		write_reg(REG_CHAN_MIN, cmin);
		write_reg(REG_CHAN_MAX, cmax);
		write_reg(REG_PULSE_MIN, wmin);
		write_reg(REG_PULSE_MAX, wmax);
		write_reg(REG_PERIOD_MIN, pmin);
		write_reg(REG_PERIOD_MAX, pmax);
		write_reg(REG_QUIET, quiet);
		write_reg(REG_LOSS, loss);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Mostly clean frames of one pulse per channel followed by an update tick,
	// with stray edges, odd widths, skipped channels and jumps in time mixed in.
	task automatic run_frames(input int quota);
		logic [TS_W-1:0] width;
		int              start;
		start = items_sent;
		while (items_sent - start < quota) begin
			for (int ch = 0; ch < 4; ch++) begin
				if ($urandom_range(0, 7) != 0) begin
					width = ($urandom_range(0, 7) == 0) ? TS_W'($urandom) :
						TS_W'($urandom_range(850, 2150));
					send_edge(CHAN_W'(ch), 1'b1, clock_us[ch]);
					send_edge(CHAN_W'(ch), 1'b0, clock_us[ch] + width);
					clock_us[ch] += ($urandom_range(0, 9) == 0) ? TS_W'($urandom) :
						TS_W'($urandom_range(2600, 24000));
				end
				if ($urandom_range(0, 9) == 0)
					send_edge(CHAN_W'($urandom), 1'($urandom), TS_W'($urandom));
			end
			ms_clock += ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) :
				$urandom_range(3, 22);
			send_tick(ms_clock);
			if ($urandom_range(0, 19) == 0)
				send_tick($urandom);
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_tick(32'd0);
		send_edge(2'd0, 1'b0, 16'd100);
		send_edge(2'd0, 1'b1, 16'd0);
		send_edge(2'd0, 1'b0, 16'd1500);
		send_edge(2'd0, 1'b1, 16'd20000);
		send_edge(2'd0, 1'b0, 16'd21500);
		send_edge(2'd0, 1'b1, 16'd40000);
		send_edge(2'd0, 1'b1, 16'd40010);
		send_edge(2'd0, 1'b0, 16'd42100);
		send_edge(2'd1, 1'b1, 16'hFFFF);
		send_edge(2'd1, 1'b0, 16'd899);
		send_edge(2'd2, 1'b1, 16'h8000);
		send_edge(2'd3, 1'b1, 16'h7FFF);
		send_edge(2'd3, 1'b0, 16'hFFFF);
		send_tick(32'hFFFF_FFF0);
		send_tick(32'hFFFF_FFFF);
		send_tick(32'd0);
		send_tick(32'd30);

		for (int ch = 0; ch < 4; ch++)
			clock_us[ch] = TS_W'($urandom);
		ms_clock = $urandom;

		set_limits(16'd0, 16'hFFFF, 16'd1, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF);
		run_frames(40);
		set_limits(16'd1800, 16'd1200, 16'd900, 16'd2100, 16'd2500, 16'd25000,
			16'hFFFF, 16'd0);
		run_frames(40);
		set_limits(16'd1000, 16'd2000, 16'd2100, 16'd900, 16'd25000, 16'd2500,
			16'd25, 16'd100);
		run_frames(15);
		set_limits(16'd1000, 16'd2000, 16'd900, 16'd2100, 16'd2500, 16'd25000,
			16'd25, 16'd100);
		run_frames(30);

		// The receiver holds off while the sender keeps offering transactions.
		calm     = 1'b1;
		hold_req <= 1'b1;
		run_frames(12);
		calm = 1'b0;
		drain();
		run_frames(40);
		calm = 1'b1;
		run_frames(30);
		drain();

		if (mismatch_count == 0)
			$display("tb_rc_pwm_pulse_capture_monitor: PASS");
		else
			$display("tb_rc_pwm_pulse_capture_monitor: FAIL");
		$finish;
	end

endmodule
